// ===== src/sha256_message_digest_defines.svh =====
// Assertion macros used by the checker file
`ifndef SHA256_MESSAGE_DIGEST_DEFINES_SVH
`define SHA256_MESSAGE_DIGEST_DEFINES_SVH
`define SHA_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("sha256 check failed");
`define SHA_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("sha256 check failed");
`endif

// ===== src/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// sha256_pkg
// Types, constants and round functions for the SHA-256 digest block.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // control from sequencer to round unit
  typedef struct packed {
    logic init;   // load working vars and schedule from chain/block
    logic step;   // run one round
    logic fold;   // add working vars into chain
    logic reset_chain;
  } rnd_ctl_t;

  localparam logic [31:0] INIT_CHAIN [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
    rotr = (x >> n) | (x << (6'd32 - {1'b0, n}));
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    big_s0 = rotr(x, 5'd2) ^ rotr(x, 5'd13) ^ rotr(x, 5'd22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    big_s1 = rotr(x, 5'd6) ^ rotr(x, 5'd11) ^ rotr(x, 5'd25);
  endfunction

  function automatic logic [31:0] sml_s0(input logic [31:0] x);
    sml_s0 = rotr(x, 5'd7) ^ rotr(x, 5'd18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sml_s1(input logic [31:0] x);
    sml_s1 = rotr(x, 5'd17) ^ rotr(x, 5'd19) ^ (x >> 10);
  endfunction

endpackage

// ===== src/sha256_round.sv =====
// ----------------------------------------------------------------------------
// sha256_round
// One shared SHA-256 round unit: working vars, schedule window, chain words.
// ----------------------------------------------------------------------------
module sha256_round (
  input  logic                  clk,
  input  logic                  rst,
  input  sha256_pkg::rnd_ctl_t  ctl,
  input  logic [5:0]            round,
  input  logic [31:0]           block [16],
  output logic [31:0]           chain [8]
);

  logic [31:0] v [8];
  logic [31:0] w [16];
  logic [31:0] wt;
  logic [31:0] t1;
  logic [31:0] t2;

  // window shifts each round; w[0] is the word for this round
  assign wt = w[0];
  assign t1 = v[7] + sha256_pkg::big_s1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
            + sha256_pkg::ROUND_K[round] + wt;
  assign t2 = sha256_pkg::big_s0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      for (int i = 0; i < 8; i++) v[i] <= chain[i];
      for (int i = 0; i < 16; i++) w[i] <= block[i];
    end else if (ctl.step) begin
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= sha256_pkg::sml_s1(w[14]) + w[9] + sha256_pkg::sml_s0(w[1]) + w[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.reset_chain) begin
      for (int i = 0; i < 8; i++) chain[i] <= sha256_pkg::INIT_CHAIN[i];
    end else if (ctl.fold) begin
      for (int i = 0; i < 8; i++) chain[i] <= chain[i] + v[i];
    end
  end

endmodule

// ===== src/sha256_message_digest.sv =====
// ----------------------------------------------------------------------------
// sha256_message_digest
// Byte-serial SHA-256: packs bytes, pads, compresses, emits eight words.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  in      | in_valid/in_stall   | sha256_pkg::in_item_t
//  out     | out_valid/out_stall | sha256_pkg::out_item_t
//
// A plain byte is taken while idle; a byte that completes a block adds a compression
// (load, 64 rounds on the shared round unit, fold).
// A final beat adds a pad step plus a compression, twice when
// the pad byte lands at byte 56 or later, then 8 output beats (held by out_stall).
// in_stall is high whenever the sequencer is not idle.
// Synchronous reset restores the initial chain and zero length.
module sha256_message_digest (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  sha256_pkg::in_item_t   in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output sha256_pkg::out_item_t  out_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_INIT = 3'd1;
  localparam logic [2:0] ST_RUN  = 3'd2;
  localparam logic [2:0] ST_FOLD = 3'd3;
  localparam logic [2:0] ST_PAD  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]  state;
  logic [5:0]  round;
  logic [60:0] count;
  logic        pad_pend;   // padding still to be placed
  logic        pad_done;   // padding placed for this message
  logic        fin;        // current compression is the final one
  logic [31:0] block [16];
  logic [31:0] chain [8];
  logic [2:0]  oidx;
  sha256_pkg::rnd_ctl_t ctl;
  logic        acc;
  logic [5:0]  pos;
  logic [63:0] bits;
  logic        len_here;

  assign in_stall = (state != ST_IDLE);
  assign acc = in_valid && !in_stall;
  assign pos = count[5:0];
  assign bits = {count, 3'b000};
  // length goes in this pad block unless the pad byte spills into a second one
  assign len_here = !pad_pend || (pos < 6'd56);

  assign ctl.init = (state == ST_INIT);
  assign ctl.step = (state == ST_RUN);
  assign ctl.fold = (state == ST_FOLD);
  assign ctl.reset_chain = (state == ST_OUT) && !out_stall && (oidx == 3'd7);

  sha256_round u_round (
    .clk(clk), .rst(rst), .ctl(ctl), .round(round), .block(block), .chain(chain)
  );

  assign out_valid = (state == ST_OUT);
  assign out_data.digest_word = chain[oidx];
  assign out_data.word_index = oidx;
  assign out_data.last_word = (oidx == 3'd7);

  always_ff @(posedge clk) begin
    if (acc && in_data.has_byte) begin
      if (pos[1:0] == 2'd0) begin
        block[pos[5:2]] <= {in_data.msg_byte, 24'd0};
      end else begin
        block[pos[5:2]][(5'd3 - {3'd0, pos[1:0]}) * 8 +: 8] <= in_data.msg_byte;
      end
    end
    if (state == ST_PAD) begin
      for (int i = 0; i < 16; i++) begin
        if (len_here && i == 14) begin
          block[i] <= bits[63:32];
        end else if (len_here && i == 15) begin
          block[i] <= bits[31:0];
        end else if (!pad_pend || 4'(i) > pos[5:2]) begin
          block[i] <= '0;
        end else if (4'(i) == pos[5:2]) begin
          if (pos[1:0] == 2'd0) block[i] <= {sha256_pkg::PAD_BYTE, 24'd0};
          else block[i][(5'd3 - {3'd0, pos[1:0]}) * 8 +: 8] <= sha256_pkg::PAD_BYTE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      round <= '0;
      count <= '0;
      pad_pend <= 1'b0;
      fin <= 1'b0;
      oidx <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (acc) begin
            pad_pend <= in_data.end_of_message;
            fin <= 1'b0;
            if (in_data.has_byte) count <= count + 61'd1;
            if (in_data.has_byte && pos == 6'd63) state <= ST_INIT;
            else if (in_data.end_of_message) state <= ST_PAD;
          end
        end
        ST_PAD: begin
          pad_pend <= 1'b0;
          fin <= len_here;
          state <= ST_INIT;
        end
        ST_INIT: begin
          round <= '0;
          state <= ST_RUN;
        end
        ST_RUN: begin
          round <= round + 6'd1;
          if (round == 6'd63) state <= ST_FOLD;
        end
        ST_FOLD: begin
          if (fin) begin
            oidx <= '0;
            state <= ST_OUT;
          end else if (pad_pend || pad_done) begin
            state <= ST_PAD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              state <= ST_IDLE;
              count <= '0;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) pad_done <= 1'b0;
    else if (state == ST_PAD) pad_done <= 1'b1;
    else if (state == ST_IDLE) pad_done <= 1'b0;
  end

endmodule

// ===== src/sha256_checker.sv =====
// ----------------------------------------------------------------------------
// sha256_checker
// Port-level checks for the SHA-256 digest block.
// ----------------------------------------------------------------------------
`include "sha256_message_digest_defines.svh"
module sha256_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input sha256_pkg::out_item_t out_data
);
  `SHA_ASSERT_IMPL(a_busy_out, clk, rst, out_valid, in_stall)
  `SHA_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))
  `SHA_ASSERT_NEXT(a_seq, clk, rst, out_valid && !out_stall && !out_data.last_word,
    out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1)
endmodule

bind sha256_message_digest sha256_checker u_chk (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
